@@ rtl/lsbr_pkg.sv @@
// Package for the LSB-first bit reader: request and result structs,
// request type and status codes, fixed widths and the read size limit.
// No dependencies.
`default_nettype none

package lsbr_pkg;

	localparam int unsigned MAX_READ_BITS    = 32;
	localparam int unsigned DEF_BUFFER_BITS  = 64;
	localparam int unsigned VALUE_W          = 32;

	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_FLUSH = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
		logic [5:0] bit_count;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] bits_value;
		logic [1:0]         status;
		logic [6:0]         bits_available;
	} rsp_t;

endpackage

`default_nettype wire

@@ rtl/lsb_first_bit_reader.sv @@
// Top level of the LSB-first bit reader: request register, result register
// and valid/stall handshake around lsbr_core. Depends on lsbr_pkg.
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  lsbr_pkg::req_t
//   rsp      out  rsp_valid / rsp_stall  lsbr_pkg::rsp_t
//
// One request per cycle while rsp is not stalled; the result is registered.
// The buffer, count and phase registers update together on each fired request.
// Reset clears the buffer and both valid flags.
// A stalled result holds the core; one more request waits in the input register.
`default_nettype none

module lsb_first_bit_reader #(
	parameter int unsigned BUFFER_BITS = lsbr_pkg::DEF_BUFFER_BITS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire lsbr_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output lsbr_pkg::rsp_t      rsp
);
	import lsbr_pkg::*;

	req_t req_s1;
	logic req_s1_valid;
	rsp_t rsp_d;
	logic hold;
	logic fire;

	assign hold      = rsp_valid && rsp_stall;
	assign fire      = req_s1_valid && !hold;
	assign req_stall = req_s1_valid && hold;

	lsbr_core #(
		.BUFFER_BITS(BUFFER_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.req   (req_s1),
		.rsp   (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1_valid <= 1'b0;
		end else if (req_valid && !req_stall) begin
			req_s1_valid <= 1'b1;
		end else if (fire) begin
			req_s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (fire) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp <= rsp_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/lsbr_core.sv @@
// Bit buffer state and combinational request processing: push, read, flush.
// Depends on lsbr_pkg.
`default_nettype none

module lsbr_core #(
	parameter int unsigned BUFFER_BITS = lsbr_pkg::DEF_BUFFER_BITS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire lsbr_pkg::req_t req,
	output lsbr_pkg::rsp_t      rsp
);
	import lsbr_pkg::*;

	localparam int unsigned CNT_W = $clog2(BUFFER_BITS + 1);

	logic [BUFFER_BITS-1:0] buf_q;
	logic [CNT_W-1:0]       valid_q;
	logic [2:0]             phase_q;

	logic [BUFFER_BITS-1:0] buf_d;
	logic [CNT_W-1:0]       valid_d;
	logic [2:0]             phase_d;
	logic [CNT_W-1:0]       count_ext;
	logic [CNT_W-1:0]       rest_ext;
	logic [CNT_W:0]         push_end;
	logic [VALUE_W-1:0]     read_mask;
	logic [VALUE_W-1:0]     value;
	logic [1:0]             status;

	always_comb begin
		count_ext = CNT_W'(req.bit_count);
		rest_ext  = CNT_W'(3'(3'd0 - phase_q));
		push_end  = {1'b0, valid_q} + (CNT_W + 1)'(8);
		read_mask = VALUE_W'(~({(VALUE_W + 1){1'b1}} << req.bit_count));
		buf_d     = buf_q;
		valid_d   = valid_q;
		phase_d   = phase_q;
		value     = '0;
		status    = ST_OK;
		case (req.req_type)
			REQ_PUSH: begin
				if (push_end > (CNT_W + 1)'(BUFFER_BITS)) begin
					status = ST_FULL;
				end else begin
					buf_d   = buf_q | (BUFFER_BITS'(req.data_byte) << valid_q);
					valid_d = push_end[CNT_W-1:0];
				end
			end
			REQ_READ: begin
				if (req.bit_count > 6'(MAX_READ_BITS) || count_ext > valid_q) begin
					status = ST_SHORT;
				end else begin
					value   = buf_q[VALUE_W-1:0] & read_mask;
					buf_d   = buf_q >> req.bit_count;
					valid_d = valid_q - count_ext;
					phase_d = phase_q + req.bit_count[2:0];
				end
			end
			REQ_FLUSH: begin
				if (rest_ext > valid_q) begin
					rest_ext = valid_q;
				end
				buf_d   = buf_q >> rest_ext;
				valid_d = valid_q - rest_ext;
				phase_d = 3'd0;
			end
			default: begin
			end
		endcase
		rsp.bits_value     = value;
		rsp.status         = status;
		rsp.bits_available = 7'(valid_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			valid_q <= '0;
			phase_q <= '0;
		end else if (fire) begin
			buf_q   <= buf_d;
			valid_q <= valid_d;
			phase_q <= phase_d;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q <= CNT_W'(BUFFER_BITS))
		else $error("buffered bit count above buffer size");

	a_clean_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(buf_q >> valid_q) == '0)
		else $error("stale bits above buffered count");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && status == ST_FULL |=> $stable(buf_q) && $stable(valid_q))
		else $error("dropped push changed buffer");

	a_flush_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.req_type == REQ_FLUSH |=> phase_q == 3'd0)
		else $error("flush left byte phase non-zero");
`endif

endmodule

`default_nettype wire

@@ tb/lsbr_checker.sv @@
// Checker for the LSB-first bit reader: watches both channels, keeps its own
// copy of the bit buffer, predicts each result and compares it field by field.
// Depends on lsbr_pkg.
module lsbr_checker #(
	parameter int unsigned BUFFER_BITS = lsbr_pkg::DEF_BUFFER_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  lsbr_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  lsbr_pkg::rsp_t rsp,
	output int             fail_count,
	output int             outstanding,
	output int             checked,
	output int             shortfalls,
	output int             overflows
);
	import lsbr_pkg::*;

	logic [127:0] stream_bits;
	int unsigned  held;
	logic [2:0]   phase;
	rsp_t         awaited[$];

	int fails = 0;
	int n_checked = 0;
	int n_short = 0;
	int n_full = 0;

	assign fail_count  = fails;
	assign outstanding = awaited.size();
	assign checked     = n_checked;
	assign shortfalls  = n_short;
	assign overflows   = n_full;

	function automatic rsp_t advance_reader(input req_t r);
		rsp_t        o;
		int unsigned n;
		int unsigned rest;
		logic [63:0] mask;
		o = '0;
		n = r.bit_count;
		case (r.req_type)
		REQ_PUSH: begin
			if (held + 8 > BUFFER_BITS) begin
				o.status = ST_FULL;
			end else begin
				stream_bits = stream_bits | (128'(r.data_byte) << held);
				held = held + 8;
			end
		end
		REQ_READ: begin
			if (n > MAX_READ_BITS || n > held) begin
				o.status = ST_SHORT;
			end else if (n > 0) begin
				mask = (64'd1 << n) - 64'd1;
				o.bits_value = stream_bits[31:0] & mask[31:0];
				stream_bits = stream_bits >> n;
				held = held - n;
				phase = phase + 3'(n);
			end
		end
		REQ_FLUSH: begin
			// drop the rest of a partly used byte
			rest = (8 - int'(phase)) % 8;
			if (rest > held)
				rest = held;
			stream_bits = stream_bits >> rest;
			held = held - rest;
			phase = 3'd0;
		end
		default: ;
		endcase
		o.bits_available = 7'(held);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			stream_bits = '0;
			held = 0;
			phase = 3'd0;
			awaited.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited.size() == 0) begin
					fails++;
					$display("%0t: unexpected result %p", $time, rsp);
				end else begin
					want = awaited.pop_front();
					n_checked++;
					if (want.status == ST_SHORT)
						n_short++;
					if (want.status == ST_FULL)
						n_full++;
					if (rsp.bits_value !== want.bits_value) begin
						fails++;
						$display("%0t: bits_value expected %h got %h", $time,
							want.bits_value, rsp.bits_value);
					end
					if (rsp.status !== want.status) begin
						fails++;
						$display("%0t: status expected %0d got %0d", $time,
							want.status, rsp.status);
					end
					if (rsp.bits_available !== want.bits_available) begin
						fails++;
						$display("%0t: bits_available expected %0d got %0d", $time,
							want.bits_available, rsp.bits_available);
					end
				end
			end
			if (req_valid && !req_stall)
				awaited.insert(awaited.size(), advance_reader(req));
		end
	end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for lsb_first_bit_reader: clock, reset, request stimulus,
// random result stalls, watchdog and verdict. Depends on lsbr_pkg,
// lsb_first_bit_reader and lsbr_checker.
module tb_top;
	import lsbr_pkg::*;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int RANDOM_PER_PHASE = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int fail_count;
	int outstanding;
	int checked;
	int shortfalls;
	int overflows;

	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int sent = 0;
	int burst_kind = 0;
	int burst_left = 0;

	lsb_first_bit_reader dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	lsbr_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.checked(checked),
		.shortfalls(shortfalls),
		.overflows(overflows)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic req_t mk(input logic [1:0] kind, input logic [7:0] b,
			input logic [5:0] cnt);
		req_t r;
		r.req_type = kind;
		r.data_byte = b;
		r.bit_count = cnt;
		return r;
	endfunction

	function automatic req_t random_req();
		req_t r;
		int   pick;
		r = mk(2'($urandom_range(3)), 8'($urandom), 6'($urandom_range(63)));
		if (burst_left == 0) begin
			burst_kind = $urandom_range(2);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		// a few malformed requests amid the bursts
		if ($urandom_range(99) < 8)
			return r;
		pick = $urandom_range(99);
		case (burst_kind)
		0: begin
			r.req_type = REQ_PUSH;
		end
		1: begin
			r.req_type = REQ_READ;
			r.bit_count = 6'($urandom_range(1, 32));
		end
		default: begin
			if (pick < 40) begin
				r.req_type = REQ_PUSH;
			end else if (pick < 82) begin
				r.req_type = REQ_READ;
				r.bit_count = 6'($urandom_range(12));
			end else begin
				r.req_type = REQ_FLUSH;
			end
		end
		endcase
		return r;
	endfunction

	task automatic send(input req_t r);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk iff !req_stall);
	endtask

	// hold requests back until every result is in
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	initial begin
		req_t directed[$];
		req_t r;
		int   idle_set[4];
		int   stall_set[4];
		int   count;
		idle_set = '{0, 52, 0, 10};
		stall_set = '{0, 0, 52, 10};
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty buffer, fill to full, overflow, reads, flushes, odd requests
		directed = '{
			mk(REQ_READ, 8'h00, 6'd0), mk(REQ_READ, 8'h00, 6'd1),
			mk(REQ_FLUSH, 8'h00, 6'd0), mk(REQ_PUSH, 8'hA5, 6'd0),
			mk(REQ_PUSH, 8'hFF, 6'd0), mk(REQ_PUSH, 8'h00, 6'd0),
			mk(REQ_PUSH, 8'h3C, 6'd0), mk(REQ_PUSH, 8'h81, 6'd0),
			mk(REQ_PUSH, 8'h5A, 6'd0), mk(REQ_PUSH, 8'h7E, 6'd0),
			mk(REQ_PUSH, 8'hC3, 6'd0), mk(REQ_PUSH, 8'h99, 6'd0),
			mk(REQ_READ, 8'h00, 6'd32), mk(REQ_READ, 8'h00, 6'd3),
			mk(REQ_FLUSH, 8'hFF, 6'd63), mk(REQ_FLUSH, 8'h00, 6'd0),
			mk(REQ_READ, 8'h00, 6'd33), mk(REQ_READ, 8'hFF, 6'd63),
			mk(REQ_NONE, 8'hFF, 6'd63), mk(REQ_READ, 8'h00, 6'd24),
			mk(REQ_READ, 8'h00, 6'd1), mk(REQ_PUSH, 8'h11, 6'd0),
			mk(REQ_READ, 8'h00, 6'd8)
		};
		foreach (directed[i]) begin
			send(directed[i]);
			sent++;
		end
		drain();

		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_set[p];
			stall_pct = stall_set[p];
			count = 0;
			while (count < RANDOM_PER_PHASE) begin
				r = random_req();
				send(r);
				sent++;
				if (r.req_type != REQ_NONE)
					count++;
			end
			drain();
		end

		stall_pct = 0;
		req_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (8) @(posedge clk);

		$display("Sent %0d requests over four idle/stall phases; %0d results checked,",
			sent, checked);
		$display("including %0d short reads and %0d pushes into a full buffer.",
			shortfalls, overflows);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ files.f @@
rtl/lsbr_pkg.sv
rtl/lsbr_core.sv
rtl/lsb_first_bit_reader.sv
tb/lsbr_checker.sv
tb/tb_top.sv
